// File: src/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned IN_TIME_W  = 16;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned IDX_OUT_W  = 4;
  localparam int unsigned OUT_TIME_W = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic load;
    logic begin_tick;
    logic scan;
    logic start_upd;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic pipe_busy;
  } status_t;

endpackage

// File: src/pps_ctrl.sv
// Controller state machine that sequences loads and the two passes of a tick.
module pps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            opcode_i,
  input  pps_pkg::status_t status_i,
  output pps_pkg::cmd_t    cmd_o,
  output logic            busy_o,
  output logic            strobe_o
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q, strobe_d;
  logic   pass_done;

  assign pass_done = !status_i.more && !status_i.pipe_busy;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    strobe_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_TICK) begin
            cmd_o.begin_tick = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (pass_done) begin
          cmd_o.start_upd = 1'b1;
          state_d         = S_UPD;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_UPD: begin
        if (pass_done) begin
          cmd_o.finish = 1'b1;
          strobe_d     = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.update = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

endmodule

// File: src/pps_datapath.sv
// Datapath with the process table memory, the minimum search and the wait update.
module pps_datapath #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pps_pkg::cmd_t                   cmd_i,
  output pps_pkg::status_t                status_o,
  input  logic [pps_pkg::IN_TIME_W-1:0]   arrival_time_i,
  input  logic [pps_pkg::IN_TIME_W-1:0]   service_time_i,
  input  logic [pps_pkg::PRIO_W-1:0]      priority_level_i,
  output logic [pps_pkg::IDX_OUT_W-1:0]   process_index_o,
  output logic                            idle_o,
  output logic                            finished_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]  finish_time_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]  wait_total_o,
  output logic                            all_done_o
);
  import pps_pkg::*;

  localparam int unsigned IW      = $clog2(MAX_PROCESSES);
  localparam int unsigned CW      = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TB      = TIME_BITS;
  localparam int unsigned EW      = 3 * TB + PRIO_W;
  localparam int unsigned MW      = (TB > IN_TIME_W) ? TB : IN_TIME_W;
  localparam int unsigned PRIO_LO = TB;
  localparam int unsigned REM_LO  = TB + PRIO_W;
  localparam int unsigned ARR_LO  = 2 * TB + PRIO_W;
  localparam logic [TB-1:0] TIME_MAX = '1;
  localparam logic [CW-1:0] DEPTH    = CW'(MAX_PROCESSES);

  logic [EW-1:0]     mem_q [MAX_PROCESSES];
  logic [EW-1:0]     rdata_q;
  logic [CW-1:0]     cnt_q, addr_q;
  logic [TB-1:0]     time_q;
  logic              valid_q;
  logic [IW-1:0]     didx_q, pick_q;
  logic              have_q, done_q, all_q;
  logic [PRIO_W-1:0] best_q;
  logic [TB-1:0]     wout_q;

  logic              more, rd_en, wr_en, load_ok;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [TB-1:0]     r_arr, r_rem, r_wait, new_rem, new_wait;
  logic [PRIO_W-1:0] r_prio;
  logic              r_ready, is_pick;
  logic [MW-1:0]     arr_ext, srv_ext;
  logic [TB-1:0]     arr_c, srv_c;

  assign more    = addr_q < cnt_q;
  assign rd_en   = (cmd_i.scan || cmd_i.update) && more;
  assign load_ok = cmd_i.load && (cnt_q < DEPTH);

  assign r_wait  = rdata_q[TB-1:0];
  assign r_prio  = rdata_q[PRIO_LO +: PRIO_W];
  assign r_rem   = rdata_q[REM_LO +: TB];
  assign r_arr   = rdata_q[ARR_LO +: TB];
  assign r_ready = (r_arr <= time_q) && (r_rem != '0);
  assign is_pick = have_q && (didx_q == pick_q);

  assign new_rem  = is_pick ? (r_rem - TB'(1)) : r_rem;
  assign new_wait = (have_q && !is_pick && r_ready && (r_wait != TIME_MAX)) ?
                    (r_wait + TB'(1)) : r_wait;

  assign arr_ext = MW'(arrival_time_i);
  assign srv_ext = MW'(service_time_i);
  assign arr_c   = (arr_ext > MW'(TIME_MAX)) ? TIME_MAX : TB'(arr_ext);
  assign srv_c   = (srv_ext > MW'(TIME_MAX)) ? TIME_MAX : TB'(srv_ext);

  assign wr_en   = load_ok || (cmd_i.update && valid_q);
  assign wr_addr = cmd_i.load ? cnt_q[IW-1:0] : didx_q;
  assign wr_data = cmd_i.load ? {arr_c, srv_c, priority_level_i, {TB{1'b0}}}
                              : {r_arr, new_rem, r_prio, new_wait};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      time_q  <= '0;
      addr_q  <= '0;
      valid_q <= 1'b0;
      didx_q  <= '0;
      pick_q  <= '0;
      best_q  <= '0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
      wout_q  <= '0;
      all_q   <= 1'b1;
    end else begin
      valid_q <= rd_en;
      if (load_ok) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.begin_tick || cmd_i.start_upd) begin
        addr_q <= '0;
      end else if (rd_en) begin
        addr_q <= addr_q + CW'(1);
      end
      if (rd_en) begin
        didx_q <= addr_q[IW-1:0];
      end
      if (cmd_i.begin_tick) begin
        pick_q <= '0;
        best_q <= '0;
        have_q <= 1'b0;
        done_q <= 1'b0;
        wout_q <= '0;
        all_q  <= 1'b1;
      end
      if (cmd_i.scan && valid_q && r_ready && (!have_q || (r_prio < best_q))) begin
        pick_q <= didx_q;
        best_q <= r_prio;
        have_q <= 1'b1;
      end
      if (cmd_i.update && valid_q) begin
        if (is_pick) begin
          done_q <= (new_rem == '0);
          wout_q <= r_wait;
        end
        if (new_rem != '0) begin
          all_q <= 1'b0;
        end
      end
      if (cmd_i.finish && (time_q != TIME_MAX)) begin
        time_q <= time_q + TB'(1);
      end
    end
  end

  assign status_o.more      = more;
  assign status_o.pipe_busy = valid_q;

  assign process_index_o = IDX_OUT_W'(pick_q);
  assign idle_o          = !have_q;
  assign finished_o      = done_q;
  assign finish_time_o   = OUT_TIME_W'(time_q);
  assign wait_total_o    = OUT_TIME_W'(wout_q);
  assign all_done_o      = all_q;

endmodule

// File: src/preemptive_priority_scheduler_core.sv
// Top level of the preemptive static-priority scheduler.
// Usage: a transaction is accepted at a rising edge with start_i high and busy_o low.
// With opcode_i low (load) the process fields are written into the next free table
// slot in that single cycle; busy_o stays low and no result follows. A load into a
// full table is dropped.
// With opcode_i high (tick) the block goes busy and makes two passes over the table
// memory, one entry read per cycle: the first pass finds the ready process with the
// smallest priority value, the second writes back remaining and wait times.
// busy_o stays high until both passes over the table are through, paced by the single
// read port of the table memory. In the cycle in which busy_o first reads low,
// strobe_o is high for exactly one cycle and the result ports hold the tick's
// outcome; the receiver takes it at the end of that cycle and cannot stall it.
// A new transaction may be started in that same strobe cycle.
// Reset empties the table, clears the time to zero and returns the controller to idle.
module preemptive_priority_scheduler_core #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            opcode_i,
  input  logic [pps_pkg::IN_TIME_W-1:0]   arrival_time_i,
  input  logic [pps_pkg::IN_TIME_W-1:0]   service_time_i,
  input  logic [pps_pkg::PRIO_W-1:0]      priority_level_i,
  output logic                            strobe_o,
  output logic [pps_pkg::IDX_OUT_W-1:0]   process_index_o,
  output logic                            idle_o,
  output logic                            finished_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]  finish_time_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]  wait_total_o,
  output logic                            all_done_o
);
  import pps_pkg::*;

  cmd_t    cmd;
  status_t status;

  pps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .strobe_o (strobe_o)
  );

  pps_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .arrival_time_i   (arrival_time_i),
    .service_time_i   (service_time_i),
    .priority_level_i (priority_level_i),
    .process_index_o  (process_index_o),
    .idle_o           (idle_o),
    .finished_o       (finished_o),
    .finish_time_o    (finish_time_o),
    .wait_total_o     (wait_total_o),
    .all_done_o       (all_done_o)
  );

endmodule

// File: src/pps_checker.sv
// Port-level checker of the scheduler core and its bind to the top level.
module pps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            opcode_i,
  input logic                            strobe_o,
  input logic [pps_pkg::IDX_OUT_W-1:0]   process_index_o,
  input logic                            idle_o,
  input logic                            finished_o,
  input logic [pps_pkg::OUT_TIME_W-1:0]  wait_total_o
);
  import pps_pkg::*;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy_o)
    else $error("Result strobe while busy.");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_TICK)) |=> busy_o)
    else $error("Tick transaction did not make the block busy.");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_LOAD)) |=> (!busy_o && !strobe_o))
    else $error("Load transaction caused busy or a result.");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> strobe_o)
    else $error("Tick ended without a result.");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && idle_o) |-> (!finished_o && (wait_total_o == '0) &&
                              (process_index_o == '0)))
    else $error("Idle tick result carries process data.");

endmodule

bind preemptive_priority_scheduler_core pps_checker u_pps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .opcode_i        (opcode_i),
  .strobe_o        (strobe_o),
  .process_index_o (process_index_o),
  .idle_o          (idle_o),
  .finished_o      (finished_o),
  .wait_total_o    (wait_total_o)
);
